### rtl/rdfl_pkg.sv
// Shared types and constants for the record directory free-list allocator.
// No dependencies; every other file in rtl/ uses this package.
package rdfl_pkg;

    // Directory geometry
    localparam int RECORDS   = 1024;
    localparam int REC_BITS  = $clog2(RECORDS);
    localparam int LINK_BITS = REC_BITS + 1;
    localparam int LEN_BITS  = 16;
    localparam int OFF_BITS  = 32;

    // Empty-list marker: one past the last record number
    localparam logic [LINK_BITS-1:0] NIL_LINK = LINK_BITS'(RECORDS);

    // Action codes
    localparam logic [1:0] ACT_ALLOC   = 2'd0;
    localparam logic [1:0] ACT_RELEASE = 2'd1;
    localparam logic [1:0] ACT_LOOKUP  = 2'd2;

    // Status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_RECORD = 3'd1;
    localparam logic [2:0] ST_ALREADY    = 3'd2;
    localparam logic [2:0] ST_DIR_FULL   = 3'd3;
    localparam logic [2:0] ST_SPACE_FULL = 3'd4;

    // One directory entry as stored in the RAM
    typedef struct packed {
        logic [OFF_BITS-1:0]  offset;
        logic [LEN_BITS-1:0]  length;
        logic [LINK_BITS-1:0] link;
        logic                 live;
    } entry_t;

    // RAM access request from the controller
    typedef struct packed {
        logic                en;
        logic                we;
        logic [REC_BITS-1:0] addr;
        entry_t              wdata;
    } mem_req_t;

    // Controller sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_REC_EVAL,
        S_WALK_EVAL,
        S_TAKE,
        S_APPEND
    } state_t;

endpackage

### rtl/rdfl_entry_ram.sv
// Directory entry store: single-port synchronous RAM with a registered read.
// Depends on rdfl_pkg for the entry and request types.
module rdfl_entry_ram
(
    input  logic              clk,
    input  rdfl_pkg::mem_req_t req,
    output rdfl_pkg::entry_t   rdata
);

    rdfl_pkg::entry_t mem [rdfl_pkg::RECORDS];
    rdfl_pkg::entry_t rdata_reg;

    // Write or registered read at one address per cycle
    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            if (req.we)
            begin
                mem[req.addr] <= req.wdata;
            end
            else
            begin
                rdata_reg <= mem[req.addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/rdfl_ctrl.sv
// Allocator sequencer: command decode, free-list walk, append, result register.
// Depends on rdfl_pkg; drives the entry RAM in rdfl_entry_ram.
module rdfl_ctrl
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         action,
    input  logic [rdfl_pkg::REC_BITS-1:0]      record_id,
    input  logic [rdfl_pkg::LEN_BITS-1:0]      request_length,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rdfl_pkg::OFF_BITS-1:0]      cfg_data,
    output rdfl_pkg::mem_req_t                 mem_req,
    input  rdfl_pkg::entry_t                   mem_rdata,
    output logic                               done,
    output logic [2:0]                         status,
    output logic [rdfl_pkg::REC_BITS-1:0]      granted_record,
    output logic [rdfl_pkg::OFF_BITS-1:0]      data_offset,
    output logic [rdfl_pkg::LEN_BITS-1:0]      data_length,
    output logic                               is_live
);

    localparam int LB = rdfl_pkg::LINK_BITS;
    localparam int RB = rdfl_pkg::REC_BITS;
    localparam int OB = rdfl_pkg::OFF_BITS;
    localparam int NB = rdfl_pkg::LEN_BITS;

    rdfl_pkg::state_t state_reg, state_next;

    // Directory registers
    logic [LB-1:0] next_record_reg, next_record_next;
    logic [LB-1:0] free_head_reg, free_head_next;
    logic [OB-1:0] data_end_reg, data_end_next;
    logic [OB-1:0] limit_reg, limit_next;

    // Command latch and walk registers
    logic [1:0]       act_reg, act_next;
    logic [RB-1:0]    rec_reg, rec_next;
    logic [NB-1:0]    len_reg, len_next;
    logic [LB-1:0]    cur_reg, cur_next;
    logic [LB-1:0]    prev_reg, prev_next;
    rdfl_pkg::entry_t prev_ent_reg, prev_ent_next;
    rdfl_pkg::entry_t cur_ent_reg, cur_ent_next;

    // Result register
    logic          done_reg, done_next;
    logic [2:0]    status_reg, status_next;
    logic [RB-1:0] grant_reg, grant_next;
    logic [OB-1:0] off_reg, off_next;
    logic [NB-1:0] len_out_reg, len_out_next;
    logic          live_reg, live_next;

    // Shared conditions
    logic          accept;
    logic          rec_valid;
    logic          head_empty;
    logic          len_match;
    logic          link_end;
    logic          dir_full;
    logic          space_full;
    logic [OB:0]   end_sum;

    assign accept     = start && (state_reg == rdfl_pkg::S_IDLE);
    assign rec_valid  = (rec_reg != '0) && ({1'b0, rec_reg} < next_record_reg);
    assign head_empty = (free_head_reg == rdfl_pkg::NIL_LINK);
    assign len_match  = (mem_rdata.length == len_reg);
    assign link_end   = (mem_rdata.link == rdfl_pkg::NIL_LINK);
    assign dir_full   = (next_record_reg >= LB'(rdfl_pkg::RECORDS));
    assign end_sum    = {1'b0, data_end_reg} + (OB+1)'(1) + (OB+1)'(len_reg);
    assign space_full = end_sum > {1'b0, limit_reg};

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rdfl_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = rdfl_pkg::S_DISPATCH;
                end
            end
            rdfl_pkg::S_DISPATCH:
            begin
                case (act_reg)
                    rdfl_pkg::ACT_ALLOC:
                    begin
                        state_next = head_empty ? rdfl_pkg::S_APPEND
                                                : rdfl_pkg::S_WALK_EVAL;
                    end
                    rdfl_pkg::ACT_RELEASE, rdfl_pkg::ACT_LOOKUP:
                    begin
                        state_next = rec_valid ? rdfl_pkg::S_REC_EVAL : rdfl_pkg::S_IDLE;
                    end
                    default:
                    begin
                        state_next = rdfl_pkg::S_IDLE;
                    end
                endcase
            end
            rdfl_pkg::S_REC_EVAL:
            begin
                state_next = rdfl_pkg::S_IDLE;
            end
            rdfl_pkg::S_WALK_EVAL:
            begin
                if (len_match)
                begin
                    state_next = rdfl_pkg::S_TAKE;
                end
                else if (link_end)
                begin
                    state_next = rdfl_pkg::S_APPEND;
                end
            end
            rdfl_pkg::S_TAKE, rdfl_pkg::S_APPEND:
            begin
                state_next = rdfl_pkg::S_IDLE;
            end
            default:
            begin
                state_next = rdfl_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath, RAM requests and result
    always_comb
    begin
        next_record_next = next_record_reg;
        free_head_next   = free_head_reg;
        data_end_next    = data_end_reg;
        limit_next       = limit_reg;
        act_next         = act_reg;
        rec_next         = rec_reg;
        len_next         = len_reg;
        cur_next         = cur_reg;
        prev_next        = prev_reg;
        prev_ent_next    = prev_ent_reg;
        cur_ent_next     = cur_ent_reg;
        done_next        = 1'b0;
        status_next      = status_reg;
        grant_next       = grant_reg;
        off_next         = off_reg;
        len_out_next     = len_out_reg;
        live_next        = live_reg;
        mem_req          = '0;

        // Config register write
        if (cfg_valid)
        begin
            limit_next = cfg_data;
        end

        case (state_reg)
            rdfl_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    act_next = action;
                    rec_next = record_id;
                    len_next = request_length;
                end
            end
            rdfl_pkg::S_DISPATCH:
            begin
                case (act_reg)
                    rdfl_pkg::ACT_ALLOC:
                    begin
                        // Start the walk at the list head
                        cur_next  = free_head_reg;
                        prev_next = rdfl_pkg::NIL_LINK;
                        if (!head_empty)
                        begin
                            mem_req.en   = 1'b1;
                            mem_req.addr = free_head_reg[RB-1:0];
                        end
                    end
                    rdfl_pkg::ACT_RELEASE, rdfl_pkg::ACT_LOOKUP:
                    begin
                        if (rec_valid)
                        begin
                            mem_req.en   = 1'b1;
                            mem_req.addr = rec_reg;
                        end
                        else
                        begin
                            done_next    = 1'b1;
                            status_next  = rdfl_pkg::ST_BAD_RECORD;
                            grant_next   = rec_reg;
                            off_next     = '0;
                            len_out_next = '0;
                            live_next    = 1'b0;
                        end
                    end
                    default:
                    begin
                        // Unused action code
                        done_next    = 1'b1;
                        status_next  = rdfl_pkg::ST_BAD_RECORD;
                        grant_next   = rec_reg;
                        off_next     = '0;
                        len_out_next = '0;
                        live_next    = 1'b0;
                    end
                endcase
            end
            rdfl_pkg::S_REC_EVAL:
            begin
                done_next  = 1'b1;
                grant_next = rec_reg;
                if (act_reg == rdfl_pkg::ACT_RELEASE)
                begin
                    if (!mem_rdata.live)
                    begin
                        status_next  = rdfl_pkg::ST_ALREADY;
                        off_next     = '0;
                        len_out_next = '0;
                        live_next    = 1'b0;
                    end
                    else
                    begin
                        // Push onto the free-list head
                        mem_req.en         = 1'b1;
                        mem_req.we         = 1'b1;
                        mem_req.addr       = rec_reg;
                        mem_req.wdata      = mem_rdata;
                        mem_req.wdata.link = free_head_reg;
                        mem_req.wdata.live = 1'b0;
                        free_head_next     = {1'b0, rec_reg};
                        status_next        = rdfl_pkg::ST_OK;
                        off_next           = mem_rdata.offset;
                        len_out_next       = mem_rdata.length;
                        live_next          = 1'b0;
                    end
                end
                else
                begin
                    status_next  = rdfl_pkg::ST_OK;
                    off_next     = mem_rdata.offset;
                    len_out_next = mem_rdata.length;
                    live_next    = mem_rdata.live;
                end
            end
            rdfl_pkg::S_WALK_EVAL:
            begin
                if (len_match)
                begin
                    // Unlink the match from its predecessor or the head
                    cur_ent_next = mem_rdata;
                    if (prev_reg == rdfl_pkg::NIL_LINK)
                    begin
                        free_head_next = mem_rdata.link;
                    end
                    else
                    begin
                        mem_req.en         = 1'b1;
                        mem_req.we         = 1'b1;
                        mem_req.addr       = prev_reg[RB-1:0];
                        mem_req.wdata      = prev_ent_reg;
                        mem_req.wdata.link = mem_rdata.link;
                    end
                end
                else if (!link_end)
                begin
                    // Step to the next free entry
                    prev_next     = cur_reg;
                    prev_ent_next = mem_rdata;
                    cur_next      = mem_rdata.link;
                    mem_req.en    = 1'b1;
                    mem_req.addr  = mem_rdata.link[RB-1:0];
                end
            end
            rdfl_pkg::S_TAKE:
            begin
                mem_req.en         = 1'b1;
                mem_req.we         = 1'b1;
                mem_req.addr       = cur_reg[RB-1:0];
                mem_req.wdata      = cur_ent_reg;
                mem_req.wdata.link = rdfl_pkg::NIL_LINK;
                mem_req.wdata.live = 1'b1;
                done_next          = 1'b1;
                status_next        = rdfl_pkg::ST_OK;
                grant_next         = cur_reg[RB-1:0];
                off_next           = cur_ent_reg.offset;
                len_out_next       = cur_ent_reg.length;
                live_next          = 1'b1;
            end
            rdfl_pkg::S_APPEND:
            begin
                done_next = 1'b1;
                if (dir_full || space_full)
                begin
                    status_next  = dir_full ? rdfl_pkg::ST_DIR_FULL : rdfl_pkg::ST_SPACE_FULL;
                    grant_next   = '0;
                    off_next     = '0;
                    len_out_next = '0;
                    live_next    = 1'b0;
                end
                else
                begin
                    mem_req.en           = 1'b1;
                    mem_req.we           = 1'b1;
                    mem_req.addr         = next_record_reg[RB-1:0];
                    mem_req.wdata.offset = data_end_reg + OB'(1);
                    mem_req.wdata.length = len_reg;
                    mem_req.wdata.link   = rdfl_pkg::NIL_LINK;
                    mem_req.wdata.live   = 1'b1;
                    next_record_next     = next_record_reg + LB'(1);
                    data_end_next        = end_sum[OB-1:0];
                    status_next          = rdfl_pkg::ST_OK;
                    grant_next           = next_record_reg[RB-1:0];
                    off_next             = data_end_reg + OB'(1);
                    len_out_next         = len_reg;
                    live_next            = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= rdfl_pkg::S_IDLE;
            next_record_reg <= LB'(1);
            free_head_reg   <= rdfl_pkg::NIL_LINK;
            data_end_reg    <= '0;
            limit_reg       <= '1;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            next_record_reg <= next_record_next;
            free_head_reg   <= free_head_next;
            data_end_reg    <= data_end_next;
            limit_reg       <= limit_next;
            done_reg        <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        act_reg      <= act_next;
        rec_reg      <= rec_next;
        len_reg      <= len_next;
        cur_reg      <= cur_next;
        prev_reg     <= prev_next;
        prev_ent_reg <= prev_ent_next;
        cur_ent_reg  <= cur_ent_next;
        status_reg   <= status_next;
        grant_reg    <= grant_next;
        off_reg      <= off_next;
        len_out_reg  <= len_out_next;
        live_reg     <= live_next;
    end

    assign busy           = (state_reg != rdfl_pkg::S_IDLE);
    assign cfg_ready      = 1'b1;
    assign done           = done_reg;
    assign status         = status_reg;
    assign granted_record = grant_reg;
    assign data_offset    = off_reg;
    assign data_length    = len_out_reg;
    assign is_live        = live_reg;

endmodule

### rtl/record_directory_free_list_allocator_top.sv
// Top level of the record directory with exact-fit free-list allocation.
// Depends on rdfl_pkg, rdfl_entry_ram and rdfl_ctrl.
//
// A command is taken when start is high and busy is low. Its result appears on
// the result ports for one cycle with done high; the receiver cannot stall it,
// and a new command may be started in that same cycle. Lookup and release of an
// existing record read the entry at dispatch and answer from evaluation; a bad
// record number or an unused action code is answered from dispatch. Allocation
// walks the free list, reading the single-port entry RAM once per visited entry,
// up to and including the match (or the whole list before an append or a
// refusal). The RAM is not cleared after reset.
// The data space limit may be written at any time the block is idle.
module record_directory_free_list_allocator_top
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     action,
    input  logic [rdfl_pkg::REC_BITS-1:0]  record_id,
    input  logic [rdfl_pkg::LEN_BITS-1:0]  request_length,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rdfl_pkg::OFF_BITS-1:0]  cfg_data,
    output logic                           done,
    output logic [2:0]                     status,
    output logic [rdfl_pkg::REC_BITS-1:0]  granted_record,
    output logic [rdfl_pkg::OFF_BITS-1:0]  data_offset,
    output logic [rdfl_pkg::LEN_BITS-1:0]  data_length,
    output logic                           is_live
);

    rdfl_pkg::mem_req_t mem_req;
    rdfl_pkg::entry_t   mem_rdata;

    // Entry store
    rdfl_entry_ram u_ram
    (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    // Sequencer
    rdfl_ctrl u_ctrl
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .action         (action),
        .record_id      (record_id),
        .request_length (request_length),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .mem_req        (mem_req),
        .mem_rdata      (mem_rdata),
        .done           (done),
        .status         (status),
        .granted_record (granted_record),
        .data_offset    (data_offset),
        .data_length    (data_length),
        .is_live        (is_live)
    );

endmodule
